>>> rtl/ctsd_pkg.sv
// Shared types, constants and helper functions for the closing-tag stream deframer.
// Depends on nothing; every other file of the block uses it.
package ctsd_pkg;

  // Widths fixed by the register and stream formats.
  localparam int BYTE_W    = 8;
  localparam int TAG_BYTES = 16;
  localparam int TAG_W     = TAG_BYTES * BYTE_W;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int TAG_IDX_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_LEN = 2'd2;

  // Whitespace characters dropped after a closing tag, and the zero byte, which is always dropped.
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

  // One result beat.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              doc_end;
  } ctsd_beat_t;

  // Shift control handed to every cell of the window.
  typedef struct packed {
    logic shift;    // a kept byte enters the window
    logic restart;  // that byte closes a document
  } ctsd_shift_t;

  // Selects byte k of the closing tag.
  function automatic logic [BYTE_W-1:0] tag_byte(input logic [TAG_W-1:0]     tag,
                                                 input logic [TAG_IDX_W-1:0] k);
    return tag[k*BYTE_W +: BYTE_W];
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_TAB);
  endfunction

endpackage

>>> rtl/ctsd_in_if.sv
// Input byte stream channel: valid/ready handshake with one raw byte per beat.
// Depends on ctsd_pkg for the byte width.
interface ctsd_in_if;
  logic                       valid;
  logic                       ready;
  logic [ctsd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/ctsd_out_if.sv
// Result channel: valid/ready handshake with one kept byte and its end-of-document flag.
// Depends on ctsd_pkg for the byte width.
interface ctsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [ctsd_pkg::BYTE_W-1:0] out_byte;
  logic                       doc_end;

  modport source (output valid, output out_byte, output doc_end, input ready);
  modport sink   (input valid, input out_byte, input doc_end, output ready);
endinterface

>>> rtl/ctsd_cell.sv
// One cell of the history window: holds one recent kept byte and whether it
// belongs to the current document, and compares it against its tag byte.
// Depends on ctsd_pkg.
module ctsd_cell #(
  parameter int POS = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ctsd_pkg::ctsd_shift_t           ctl,
  input  logic [ctsd_pkg::BYTE_W-1:0]     prev_byte,
  input  logic                            prev_valid,
  input  logic [ctsd_pkg::TAG_W-1:0]      tag,
  input  logic [ctsd_pkg::LEN_W-1:0]      tag_len,
  output logic [ctsd_pkg::BYTE_W-1:0]     byte_r,
  output logic                            valid_r,
  output logic                            ok
);
  import ctsd_pkg::*;

  logic [BYTE_W-1:0] byte_nxt;
  logic              valid_nxt;
  logic              needed;
  logic [LEN_W-1:0]  idx_full;

  // The cell takes part in the match when the tag reaches back this far.
  always_comb begin
    needed   = tag_len >= LEN_W'(POS + 2);
    idx_full = tag_len - LEN_W'(POS + 2);
    ok       = !needed ||
               (valid_r && (byte_r == tag_byte(tag, idx_full[TAG_IDX_W-1:0])));
  end

  // Shift from the neighbor; a closed document invalidates the whole window.
  always_comb begin
    byte_nxt  = byte_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      byte_nxt  = prev_byte;
      valid_nxt = prev_valid && !ctl.restart;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> rtl/ctsd_obuf.sv
// Two-entry output buffer: an output register plus a skid register, so the
// input side keeps moving while a result waits. Depends on ctsd_pkg and ctsd_out_if.
module ctsd_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ctsd_pkg::ctsd_beat_t push_beat,
  output logic                 has_room,
  ctsd_out_if.source           out_if
);
  import ctsd_pkg::*;

  ctsd_beat_t main_r, main_nxt;
  ctsd_beat_t skid_r, skid_nxt;
  logic       main_valid_r, main_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  logic       pop;

  assign has_room        = !skid_valid_r;
  assign out_if.valid    = main_valid_r;
  assign out_if.out_byte = main_r.data;
  assign out_if.doc_end  = main_r.doc_end;
  assign pop             = main_valid_r && out_if.ready;

  // Fill the output register first, the skid register only under a stall.
  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_beat;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_beat;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

endmodule

>>> rtl/closing_tag_stream_deframer_top.sv
// Closing-tag stream deframer: top level with configuration registers, the cell row
// and the output buffer. Depends on ctsd_pkg, ctsd_in_if, ctsd_out_if, ctsd_cell, ctsd_obuf.
//
// Takes one byte per beat and returns each kept byte, marking with doc_end the byte that
// completes the configured closing tag (1 to MAX_FOOTER bytes, written through cfg_*).
// Zero bytes are dropped, as are space, CR, LF and tab bytes that directly follow a
// closing tag. The block accepts one byte every cycle while its output buffer has room;
// a kept byte enters that buffer when accepted. The recent kept bytes live in a row of
// MAX_FOOTER-1 cells that shift once per kept byte, and the tag compare across the whole
// row is done in the accept cycle, which sets the critical path. The two-beat buffer
// absorbs a stall on the result side, so input stalls only when both entries are full.
module closing_tag_stream_deframer_top #(
  parameter int MAX_FOOTER = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ctsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctsd_pkg::CFG_W-1:0]      cfg_data,
  ctsd_in_if.sink                         in_if,
  ctsd_out_if.source                      out_if
);
  import ctsd_pkg::*;

  localparam int NCELL = MAX_FOOTER - 1;

  logic [CFG_W-1:0] footer_lo_r, footer_lo_nxt;
  logic [CFG_W-1:0] footer_hi_r, footer_hi_nxt;
  logic [LEN_W-1:0] footer_len_r, footer_len_nxt;
  logic             skip_r, skip_nxt;

  logic [TAG_W-1:0]  tag;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  head_idx;
  logic [BYTE_W-1:0] in_b;
  logic              accept;
  logic              keep;
  logic              head_ok;
  logic              hit;
  logic              has_room;
  ctsd_shift_t       ctl;
  ctsd_beat_t        beat;

  logic [BYTE_W-1:0] cell_byte [NCELL];
  logic [NCELL-1:0]  cell_valid;
  logic [NCELL-1:0]  cell_ok;

  // Configuration registers.
  always_comb begin
    footer_lo_nxt  = footer_lo_r;
    footer_hi_nxt  = footer_hi_r;
    footer_len_nxt = footer_len_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOOTER_LO:  footer_lo_nxt  = cfg_data;
        CFG_FOOTER_HI:  footer_hi_nxt  = cfg_data;
        CFG_FOOTER_LEN: footer_len_nxt = cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      footer_lo_r  <= '0;
      footer_hi_r  <= '0;
      footer_len_r <= LEN_W'(1);
    end else begin
      footer_lo_r  <= footer_lo_nxt;
      footer_hi_r  <= footer_hi_nxt;
      footer_len_r <= footer_len_nxt;
    end
  end

  // Tag length clamped to the window size.
  always_comb begin
    tag      = {footer_hi_r, footer_lo_r};
    len_eff  = (footer_len_r > LEN_W'(MAX_FOOTER)) ? LEN_W'(MAX_FOOTER) : footer_len_r;
    head_idx = len_eff - LEN_W'(1);
  end

  // Accept and filter the incoming byte.
  assign in_if.ready = has_room;
  assign in_b        = in_if.in_byte;
  assign accept      = in_if.valid && in_if.ready;
  assign keep        = accept && (in_b != CHAR_NUL) && !(skip_r && is_space(in_b));

  // The new byte must equal the last tag byte and every needed cell must agree.
  assign head_ok = (len_eff != '0) && (in_b == tag_byte(tag, head_idx[TAG_IDX_W-1:0]));
  assign hit     = head_ok && (&cell_ok);

  assign ctl.shift   = keep;
  assign ctl.restart = hit;

  // Row of history cells, newest byte in cell zero.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_head
      ctsd_cell #(.POS(k)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_byte  (in_b),
        .prev_valid (1'b1),
        .tag        (tag),
        .tag_len    (len_eff),
        .byte_r     (cell_byte[k]),
        .valid_r    (cell_valid[k]),
        .ok         (cell_ok[k])
      );
    end else begin : g_body
      ctsd_cell #(.POS(k)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_byte  (cell_byte[k-1]),
        .prev_valid (cell_valid[k-1]),
        .tag        (tag),
        .tag_len    (len_eff),
        .byte_r     (cell_byte[k]),
        .valid_r    (cell_valid[k]),
        .ok         (cell_ok[k])
      );
    end
  end

  // Whitespace skipping after a closing tag.
  always_comb begin
    skip_nxt = skip_r;
    if (keep) begin
      skip_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
    end else begin
      skip_r <= skip_nxt;
    end
  end

  // Result beat into the output buffer.
  assign beat.data    = in_b;
  assign beat.doc_end = hit;

  ctsd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (keep),
    .push_beat (beat),
    .has_room  (has_room),
    .out_if    (out_if)
  );

  // The document-membership bits always form a run starting at the newest cell.
  a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + NCELL'(1)) & cell_valid) == '0)
    else $error("cell valid bits are not a contiguous run");

  // A match only uses bytes of the current document.
  a_hit_in_doc: assert property (@(posedge clk) disable iff (!rst_n)
    (keep && hit) |-> ($countones(cell_valid) + 1 >= int'(len_eff)))
    else $error("closing tag matched across a document boundary");

  // A closed document empties the window and arms whitespace skipping.
  a_hit_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (keep && hit) |=> (cell_valid == '0) && skip_r)
    else $error("window not restarted after a closing tag");

  // Input backpressure only while a result is waiting on the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with an empty output register");

endmodule
